@@ rtl/slsm_pkg.sv @@
// package for the skip list sorted multiset: payload structs, request codes,
// controller/datapath command and status structs; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package slsm_pkg;
	localparam int DEF_POOL_NODES = 256;
	localparam int DEF_MAX_LEVELS = 16;
	localparam logic [15:0] LFSR_SEED = 16'hACE1;
	localparam logic [15:0] LFSR_TAPS = 16'hB400;

	localparam logic [1:0] REQ_SEARCH = 2'd0;
	localparam logic [1:0] REQ_ADD    = 2'd1;
	localparam logic [1:0] REQ_ERASE  = 2'd2;
	localparam logic [1:0] REQ_RSVD   = 2'd3;  // unused, answered with no hit

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] key_value;
	} req_t;

	typedef struct packed {
		logic hit;
		logic pool_full;
	} rsp_t;

	// datapath micro-operations issued by the controller
	localparam logic [3:0] OP_NONE      = 4'd0;
	localparam logic [3:0] OP_LATCH     = 4'd1;  // capture request, start walk
	localparam logic [3:0] OP_RD_LINK   = 4'd2;  // read link(cur, lvl)
	localparam logic [3:0] OP_RD_KEY    = 4'd3;  // read key(nx)
	localparam logic [3:0] OP_ADVANCE   = 4'd4;  // cur <= nx
	localparam logic [3:0] OP_DESCEND   = 4'd5;  // path[lvl] <= cur, lvl--
	localparam logic [3:0] OP_DRAW      = 4'd6;  // one lfsr bit
	localparam logic [3:0] OP_ALLOC     = 4'd7;  // pop free node, write key
	localparam logic [3:0] OP_LNK_RD    = 4'd8;  // read link(path[idx], idx)
	localparam logic [3:0] OP_LNK_WR    = 4'd9;  // link splice write step
	localparam logic [3:0] OP_SHRINK    = 4'd10; // decrement top level
	localparam logic [3:0] OP_FREE      = 4'd11; // push node back
	localparam logic [3:0] OP_DEL_RD    = 4'd12; // read link(del, idx)

	typedef struct packed {
		logic [3:0] op;
		logic       flag;   // sub-step select inside an op
	} cmd_t;

	typedef struct packed {
		logic       nx_null;   // registered link read is null
		logic       key_lt;    // key(nx) < request key
		logic       key_eq;
		logic       lvl_zero;  // walk level index is zero
		logic       lfsr_one;  // bit about to be drawn is one
		logic       lvl_cap;   // new level reached max
		logic       lvl_done;  // splice index reached bound
		logic       pool_empty;
		logic       lnk_match; // link(path[i], i) == del
		logic       top_null;  // head link at top-1 is null and top > 1
		logic [1:0] req_type;
	} sts_t;
endpackage
`default_nettype wire

@@ rtl/slsm_datapath.sv @@
// skip list datapath: key, link, head and free-stack stores plus walk registers
// depends on slsm_pkg
`timescale 1ns / 1ps
`default_nettype none
module slsm_datapath #(
	parameter int POOL_NODES = slsm_pkg::DEF_POOL_NODES,
	parameter int MAX_LEVELS = slsm_pkg::DEF_MAX_LEVELS
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire slsm_pkg::req_t req,
	input  wire slsm_pkg::cmd_t cmd,
	output slsm_pkg::sts_t     sts
);
	import slsm_pkg::*;
	localparam int NW = $clog2(POOL_NODES + 1);      // link width, null = POOL_NODES
	localparam int IW = $clog2(POOL_NODES);          // node index width
	localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int TW = $clog2(MAX_LEVELS + 1);
	localparam logic [NW-1:0] NULL_LINK = NW'(POOL_NODES);

	logic [31:0]   key_mem [POOL_NODES];
	logic [NW-1:0] link_mem [POOL_NODES*MAX_LEVELS];
	logic [IW-1:0] free_mem [POOL_NODES];
	logic [NW-1:0] head_q [MAX_LEVELS];
	logic [NW-1:0] path_q [MAX_LEVELS];

	logic [31:0]   key_q, rkey_q;
	logic [1:0]    type_q;
	logic [NW-1:0] cur_q, nx_q, del_q, node_q, lnk_q;
	logic [LW-1:0] lvl_q;
	logic [TW-1:0] top_q, new_q, idx_q;
	logic [NW-1:0] free_cnt_q;
	logic [NW-1:0] low_q;
	logic [15:0]   lfsr_q;
	logic [IW-1:0] fs_q;

	// link address helpers
	function automatic logic [$clog2(POOL_NODES*MAX_LEVELS)-1:0] laddr(
		input logic [NW-1:0] n, input logic [LW-1:0] l);
		laddr = $clog2(POOL_NODES*MAX_LEVELS)'(n[IW-1:0] * MAX_LEVELS + l);
	endfunction

	logic [LW-1:0] idx_l;
	logic [LW-1:0] top_m1;
	logic [NW-1:0] p_sel;
	logic          cur_head, p_head;
	assign idx_l    = idx_q[LW-1:0];
	assign top_m1   = LW'(top_q - TW'(1));
	assign p_sel    = path_q[idx_l];
	assign cur_head = (cur_q == NULL_LINK);
	assign p_head   = (p_sel == NULL_LINK);

	// free stack entries below the lowest count ever reached were never
	// written, so a pop from there uses the entry's own index as the node
	logic [IW-1:0] pop_idx;
	logic [NW-1:0] pop_node;
	assign pop_idx  = IW'(free_cnt_q - NW'(1));

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_RD_KEY: rkey_q <= key_mem[nx_q[IW-1:0]];
			OP_RD_LINK: lnk_q <= link_mem[laddr(cur_q, lvl_q)];
			OP_LNK_RD: lnk_q <= link_mem[laddr(cmd.flag ? node_q : p_sel, idx_l)];
			OP_DEL_RD: lnk_q <= link_mem[laddr(del_q, idx_l)];
			OP_ALLOC: begin
				if (cmd.flag) key_mem[pop_node[IW-1:0]] <= key_q;
				else fs_q <= free_mem[pop_idx];
			end
			OP_LNK_WR: begin
				// flag 0: node.link = next; flag 1: p.link = node (or del's next)
				if (!cmd.flag) begin
					if (node_q != NULL_LINK) link_mem[laddr(node_q, idx_l)] <= nx_q;
				end else if (!p_head) begin
					link_mem[laddr(p_sel, idx_l)] <= (type_q == REQ_ADD) ? node_q : lnk_q;
				end
			end
			OP_FREE: free_mem[free_cnt_q[IW-1:0]] <= del_q[IW-1:0];
			default: ;
		endcase
	end
	assign pop_node = (free_cnt_q == low_q) ? NW'(pop_idx) : NW'(fs_q);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_LEVELS; i++) head_q[i] <= NULL_LINK;
			top_q      <= TW'(1);
			free_cnt_q <= NW'(POOL_NODES);
			low_q      <= NW'(POOL_NODES);
			lfsr_q     <= LFSR_SEED;
		end else begin
			unique case (cmd.op)
				OP_DRAW: begin
					lfsr_q <= (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_TAPS : 16'h0);
					if (cmd.flag && new_q > top_q) top_q <= new_q;
				end
				OP_ALLOC: if (cmd.flag) begin
					free_cnt_q <= free_cnt_q - NW'(1);
					if (free_cnt_q == low_q) low_q <= free_cnt_q - NW'(1);
				end
				OP_LNK_WR: if (cmd.flag && p_head)
					head_q[idx_l] <= (type_q == REQ_ADD) ? node_q : lnk_q;
				OP_SHRINK: top_q <= top_q - TW'(1);
				OP_FREE: if (free_cnt_q < NW'(POOL_NODES))
					free_cnt_q <= free_cnt_q + NW'(1);
				default: ;
			endcase
		end
	end

	// walk registers; payload, no reset
	logic          rd_head_s1;
	logic [NW-1:0] head_val_s1;
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LATCH: begin
				key_q  <= {req.key_value[31] ^ 1'b1, req.key_value[30:0]};
				type_q <= req.req_type;
				cur_q  <= NULL_LINK;
				lvl_q  <= top_m1;
				new_q  <= TW'(1);
				idx_q  <= TW'(0);
			end
			OP_RD_LINK: begin
				rd_head_s1  <= cur_head;
				head_val_s1 <= head_q[lvl_q];
			end
			OP_LNK_RD: begin
				rd_head_s1  <= !cmd.flag && p_head;
				head_val_s1 <= head_q[idx_l];
			end
			OP_DEL_RD: rd_head_s1 <= 1'b0;
			OP_ADVANCE: cur_q <= nx_q;
			OP_DESCEND: begin
				path_q[lvl_q] <= cur_q;
				if (lvl_q != LW'(0)) lvl_q <= lvl_q - LW'(1);
			end
			OP_ALLOC: begin
				if (!cmd.flag) node_q <= NULL_LINK;
				else node_q <= pop_node;
				idx_q <= new_q - TW'(1);
			end
			OP_LNK_WR: if (cmd.flag && type_q == REQ_ADD) idx_q <= idx_q - TW'(1);
			OP_SHRINK: ;
			OP_FREE: ;
			OP_NONE: begin
				// flag: record del and set index for erase pass
				if (cmd.flag) begin
					del_q <= nx_q;
					idx_q <= TW'(0);
				end
			end
			OP_DRAW: begin
				if (lfsr_q[0] && new_q < TW'(MAX_LEVELS)) new_q <= new_q + TW'(1);
				// levels above the old top start from the head
				if (cmd.flag && new_q > top_q) begin
					for (int i = 0; i < MAX_LEVELS; i++)
						if (TW'(i) >= top_q && TW'(i) < new_q) path_q[i] <= NULL_LINK;
				end
			end
			OP_RD_KEY: ;
			default: ;
		endcase
		if (cmd.op == OP_DEL_RD && cmd.flag) idx_q <= idx_q + TW'(1);
	end

	// the link read result, head or memory
	always_comb nx_q = rd_head_s1 ? head_val_s1 : lnk_q;

	assign sts.nx_null    = (nx_q == NULL_LINK);
	assign sts.key_lt     = rkey_q < key_q;
	assign sts.key_eq     = rkey_q == key_q;
	assign sts.lvl_zero   = (lvl_q == LW'(0));
	assign sts.lfsr_one   = lfsr_q[0];
	assign sts.lvl_cap    = (new_q >= TW'(MAX_LEVELS));
	assign sts.lvl_done   = (type_q == REQ_ADD) ? (idx_q == TW'(0)) : (idx_q >= top_q - TW'(1));
	assign sts.pool_empty = (free_cnt_q == NW'(0));
	assign sts.lnk_match  = (nx_q == del_q);
	assign sts.top_null   = (top_q > TW'(1)) && (head_q[top_m1] == NULL_LINK);
	assign sts.req_type   = type_q;
endmodule
`default_nettype wire

@@ rtl/slsm_ctrl.sv @@
// skip list controller: sequences walk, level draw, splice and unlink
// depends on slsm_pkg
`timescale 1ns / 1ps
`default_nettype none
module slsm_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	output logic                done,
	output slsm_pkg::rsp_t      rsp,
	input  wire slsm_pkg::sts_t sts,
	output slsm_pkg::cmd_t      cmd
);
	import slsm_pkg::*;
	localparam logic [4:0] S_IDLE = 5'd0,  S_LINK = 5'd1,  S_LWAIT = 5'd2,
		S_KEY = 5'd3, S_CMP = 5'd4, S_DESC = 5'd5, S_FIN_RD = 5'd6,
		S_FIN_W = 5'd7, S_FIN_C = 5'd9, S_DRAW = 5'd10,
		S_POP = 5'd12, S_ALLOC = 5'd13, S_SP_RD = 5'd14,
		S_SP_W = 5'd15, S_SP_P = 5'd17, S_DL_RD = 5'd18,
		S_DL_W = 5'd19, S_DL_X = 5'd20, S_DL_N = 5'd21, S_SHR = 5'd22,
		S_FREE = 5'd23, S_RESP = 5'd24, S_DL_PW = 5'd25;
	logic [4:0] state_q, state_d;
	rsp_t rsp_q, rsp_d;

	always_comb begin
		state_d = state_q;
		rsp_d   = rsp_q;
		cmd     = '{op: OP_NONE, flag: 1'b0};
		unique case (state_q)
			S_IDLE: if (start) begin
				cmd = '{op: OP_LATCH, flag: 1'b0};
				state_d = S_LINK;
			end
			S_LINK: begin
				rsp_d = '{hit: 1'b0, pool_full: 1'b0};
				if (sts.req_type == REQ_ADD && sts.pool_empty) begin
					rsp_d.pool_full = 1'b1;
					state_d = S_RESP;
				end else if (sts.req_type != REQ_SEARCH && sts.req_type != REQ_ADD &&
				             sts.req_type != REQ_ERASE) begin
					state_d = S_RESP;
				end else begin
					cmd = '{op: OP_RD_LINK, flag: 1'b0};
					state_d = S_LWAIT;
				end
			end
			S_LWAIT: begin
				if (sts.nx_null) state_d = S_DESC;
				else begin
					cmd = '{op: OP_RD_KEY, flag: 1'b0};
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				if (sts.key_lt) begin
					cmd = '{op: OP_ADVANCE, flag: 1'b0};
					state_d = S_KEY;
				end else state_d = S_DESC;
			end
			S_KEY: begin
				cmd = '{op: OP_RD_LINK, flag: 1'b0};
				state_d = S_LWAIT;
			end
			S_DESC: begin
				cmd = '{op: OP_DESCEND, flag: 1'b0};
				state_d = sts.lvl_zero ? S_FIN_RD : S_KEY;
			end
			S_FIN_RD: begin
				// re-read link(path[0],0) through the splice read port
				cmd = '{op: OP_LNK_RD, flag: 1'b0};
				state_d = S_FIN_W;
			end
			S_FIN_W: begin
				if (sts.req_type == REQ_ADD) state_d = S_DRAW;
				else if (sts.nx_null) state_d = S_RESP;
				else begin
					cmd = '{op: OP_RD_KEY, flag: 1'b0};
					state_d = S_FIN_C;
				end
			end
			S_FIN_C: begin
				if (sts.key_eq) begin
					rsp_d.hit = 1'b1;
					if (sts.req_type == REQ_ERASE) begin
						cmd = '{op: OP_NONE, flag: 1'b1};
						state_d = S_DL_RD;
					end else state_d = S_RESP;
				end else state_d = S_RESP;
			end
			S_DRAW: begin
				cmd = '{op: OP_DRAW, flag: !(sts.lfsr_one && !sts.lvl_cap)};
				state_d = (sts.lfsr_one && !sts.lvl_cap) ? S_DRAW : S_POP;
			end
			S_POP: begin
				cmd = '{op: OP_ALLOC, flag: 1'b0};
				state_d = S_ALLOC;
			end
			S_ALLOC: begin
				cmd = '{op: OP_ALLOC, flag: 1'b1};
				rsp_d.hit = 1'b1;
				state_d = S_SP_RD;
			end
			S_SP_RD: begin
				cmd = '{op: OP_LNK_RD, flag: 1'b0};
				state_d = S_SP_W;
			end
			S_SP_W: begin
				cmd = '{op: OP_LNK_WR, flag: 1'b0};
				state_d = S_SP_P;
			end
			S_SP_P: begin
				cmd = '{op: OP_LNK_WR, flag: 1'b1};
				state_d = sts.lvl_done ? S_RESP : S_SP_RD;
			end
			S_DL_RD: begin
				cmd = '{op: OP_LNK_RD, flag: 1'b0};
				state_d = S_DL_X;
			end
			S_DL_X: begin
				if (sts.lnk_match) begin
					cmd = '{op: OP_DEL_RD, flag: 1'b0};
					state_d = S_DL_PW;
				end else state_d = S_DL_N;
			end
			S_DL_PW: begin
				cmd = '{op: OP_LNK_WR, flag: 1'b1};
				state_d = S_DL_W;
			end
			S_DL_W: state_d = S_DL_N;
			S_DL_N: begin
				if (sts.lvl_done) state_d = S_SHR;
				else begin
					cmd = '{op: OP_DEL_RD, flag: 1'b1};
					state_d = S_DL_RD;
				end
			end
			S_SHR: begin
				if (sts.top_null) cmd = '{op: OP_SHRINK, flag: 1'b0};
				else state_d = S_FREE;
			end
			S_FREE: begin
				cmd = '{op: OP_FREE, flag: 1'b0};
				state_d = S_RESP;
			end
			S_RESP: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp_q   <= '0;
		end else begin
			state_q <= state_d;
			rsp_q   <= rsp_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_RESP);
	assign rsp  = rsp_q;
endmodule
`default_nettype wire

@@ rtl/skip_list_sorted_multiset.sv @@
// top level of the skip list sorted multiset: controller plus datapath
// depends on slsm_pkg, slsm_ctrl, slsm_datapath
`timescale 1ns / 1ps
`default_nettype none
// channel   | ports                 | marked by
// request   | req (req_t)           | start high while busy low
// result    | rsp (rsp_t)           | done high for one cycle
//
// one request at a time; cycles per request depend on the stored keys:
// the search walk hops links on each level, then descends, and closes on
// level 0; add then draws level bits, takes a node and splices each level;
// erase then unlinks the node on each level, shrinks the top level, frees it
// arst_n resets head links, top level, free count, free-stack low mark and lfsr
// no clearing pass; the receiver cannot stall: done lasts exactly one cycle
module skip_list_sorted_multiset #(
	parameter int POOL_NODES = slsm_pkg::DEF_POOL_NODES,
	parameter int MAX_LEVELS = slsm_pkg::DEF_MAX_LEVELS
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire slsm_pkg::req_t req,
	output logic                done,
	output slsm_pkg::rsp_t      rsp
);
	import slsm_pkg::*;
	cmd_t cmd;
	sts_t sts;

	// controller sequences the walk and the splice
	slsm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.done(done), .rsp(rsp), .sts(sts), .cmd(cmd)
	);

	// datapath holds every store
	slsm_datapath #(.POOL_NODES(POOL_NODES), .MAX_LEVELS(MAX_LEVELS)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .cmd(cmd), .sts(sts)
	);

	// a result never claims both hit and full
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(rsp.hit && rsp.pool_full)) else $error("hit with full");
	// a result ends the transfer
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after done");
	// an accepted request raises busy, so no other is accepted while it is in flight
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("not busy after accept");
endmodule
`default_nettype wire

@@ tb/slsm_checker.sv @@
// checker for the skip list sorted multiset: watches request and result transfers,
// predicts each result with its own skip list model and counts mismatches
// depends on slsm_pkg
`timescale 1ns / 1ps
module slsm_checker #(
	parameter int POOL_NODES = 256,
	parameter int MAX_LEVELS = 16
) (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           start,
	input wire logic           busy,
	input wire slsm_pkg::req_t req,
	input wire logic           done,
	input wire slsm_pkg::rsp_t rsp,
	output int                 fail_count,
	output int                 pending
);
	import slsm_pkg::*;

	localparam int NIL = POOL_NODES;

	logic [31:0] key_mem [POOL_NODES];
	int          link_mem [POOL_NODES][MAX_LEVELS];
	int          head_mem [MAX_LEVELS];
	int          free_mem [POOL_NODES];
	int          free_cnt;
	int          top_lvl;
	logic [15:0] lfsr;
	int          path [MAX_LEVELS];
	rsp_t        rsp_queue [$];

	function automatic int rd_link(int node, int lvl);
		if (node >= NIL) return head_mem[lvl];
		return link_mem[node][lvl];
	endfunction

	function automatic void wr_link(int node, int lvl, int val);
		if (node >= NIL) head_mem[lvl] = val;
		else link_mem[node][lvl] = val;
	endfunction

	function automatic logic draw_bit();
		logic b;
		b = lfsr[0];
		lfsr = lfsr >> 1;
		if (b) lfsr = lfsr ^ LFSR_TAPS;
		return b;
	endfunction

	// fills path with the last node before key on each level
	function automatic void find_path(logic [31:0] key);
		int cur;
		int nx;
		cur = NIL;
		for (int i = top_lvl - 1; i >= 0; i--) begin
			nx = rd_link(cur, i);
			while (nx != NIL && key_mem[nx] < key) begin
				cur = nx;
				nx = rd_link(cur, i);
			end
			path[i] = cur;
		end
	endfunction

	function automatic rsp_t apply_request(req_t r);
		rsp_t        res;
		logic [31:0] key;
		int          lvl;
		int          node;
		int          nx;
		res = '0;
		key = r.key_value ^ 32'h8000_0000;
		case (r.req_type)
			REQ_SEARCH: begin
				find_path(key);
				nx = rd_link(path[0], 0);
				res.hit = (nx != NIL && key_mem[nx] == key);
			end
			REQ_ADD: begin
				if (free_cnt == 0) begin
					res.pool_full = 1'b1;
				end else begin
					find_path(key);
					lvl = 1;
					while (draw_bit() && lvl < MAX_LEVELS) lvl++;
					if (lvl > top_lvl) begin
						for (int i = top_lvl; i < lvl; i++) path[i] = NIL;
						top_lvl = lvl;
					end
					free_cnt--;
					node = free_mem[free_cnt];
					key_mem[node] = key;
					for (int i = lvl - 1; i >= 0; i--) begin
						wr_link(node, i, rd_link(path[i], i));
						wr_link(path[i], i, node);
					end
					res.hit = 1'b1;
				end
			end
			REQ_ERASE: begin
				find_path(key);
				nx = rd_link(path[0], 0);
				if (nx != NIL && key_mem[nx] == key) begin
					for (int i = 0; i < top_lvl; i++)
						if (rd_link(path[i], i) == nx) wr_link(path[i], i, rd_link(nx, i));
					while (top_lvl > 1 && head_mem[top_lvl - 1] == NIL) top_lvl--;
					free_mem[free_cnt] = nx;
					free_cnt++;
					res.hit = 1'b1;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_LEVELS; i++) head_mem[i] = NIL;
			for (int i = 0; i < POOL_NODES; i++) free_mem[i] = i;
			free_cnt = POOL_NODES;
			top_lvl = 1;
			lfsr = LFSR_SEED;
			rsp_queue.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			// result first: a new request cannot finish in the cycle it is taken
			if (done) begin
				if (rsp_queue.size() == 0) begin
					$error("result with no request outstanding");
					fail_count <= fail_count + 1;
				end else begin
					want = rsp_queue.pop_front();
					if (rsp.hit !== want.hit) begin
						$error("hit: expected %0b actual %0b", want.hit, rsp.hit);
						fail_count <= fail_count + 1;
					end
					if (rsp.pool_full !== want.pool_full) begin
						$error("pool_full: expected %0b actual %0b", want.pool_full,
							rsp.pool_full);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy) rsp_queue.push_back(apply_request(req));
			pending <= rsp_queue.size();
		end
	end
endmodule

@@ tb/skip_list_sorted_multiset_tb.sv @@
// testbench top for the skip list sorted multiset: makes request stimulus
// with random bursts and gaps, gives the verdict from the checker's count
// depends on slsm_pkg, skip_list_sorted_multiset, slsm_checker
`timescale 1ns / 1ps
module skip_list_sorted_multiset_tb;
	import slsm_pkg::*;

	localparam int WATCHDOG_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	rsp_t rsp;
	int   fail_count;
	int   pending;
	int   idle_cycles = 0;
	bit   timed_out = 1'b0;

	// small key pool so searches and erases hit often
	logic signed [31:0] key_pool [16];

	always #5 clk = ~clk;

	skip_list_sorted_multiset uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	slsm_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .fail_count(fail_count), .pending(pending)
	);

	// watchdog: cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("TEST FAILED");
			$finish;
		end
	end

	// drive one request and hold it until the transfer
	task automatic send_req(logic [1:0] kind, logic signed [31:0] key);
		start <= 1'b1;
		req <= '{req_type: kind, key_value: key};
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// random gap between requests
	task automatic pause();
		int n;
		n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : 0;
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic logic signed [31:0] pick_key();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return 32'sh8000_0000;
			2: return 32'sh7fff_ffff;
			default: return key_pool[$urandom_range(0, 15)];
		endcase
	endfunction

	initial begin
		int burst;
		int fill_end;
		for (int i = 0; i < 16; i++) key_pool[i] = $urandom();
		key_pool[0] = 32'sh8000_0000;
		key_pool[1] = 32'sh7fff_ffff;
		key_pool[2] = 0;
		key_pool[3] = -1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, duplicates, erase of absent, unused type
		send_req(REQ_SEARCH, 32'sh8000_0000);
		send_req(REQ_ERASE, 32'sh7fff_ffff);
		send_req(REQ_ADD, 32'sh8000_0000);
		send_req(REQ_ADD, 32'sh7fff_ffff);
		send_req(REQ_ADD, 0);
		send_req(REQ_ADD, 0);
		send_req(REQ_ADD, -1);
		send_req(REQ_SEARCH, 32'sh8000_0000);
		send_req(REQ_SEARCH, 32'sh7fff_ffff);
		send_req(REQ_SEARCH, 1);
		send_req(REQ_RSVD, 0);
		send_req(REQ_ERASE, 0);
		send_req(REQ_SEARCH, 0);
		send_req(REQ_ERASE, 0);
		send_req(REQ_SEARCH, 0);
		send_req(REQ_ERASE, 0);
		send_req(REQ_ERASE, 32'sh8000_0000);
		send_req(REQ_ERASE, 32'sh7fff_ffff);
		send_req(REQ_ERASE, -1);
		send_req(REQ_SEARCH, -1);

		// fill the pool past full to reach pool_full, then run erases to free nodes
		fill_end = 260;
		for (int i = 0; i < fill_end; i++) begin
			send_req(REQ_ADD, pick_key());
			pause();
		end
		for (int i = 0; i < 40; i++) begin
			send_req($urandom_range(0, 1) ? REQ_ADD : REQ_SEARCH, pick_key());
			pause();
		end
		for (int i = 0; i < 300; i++) begin
			send_req(REQ_ERASE, $urandom_range(0, 3) == 0 ? $urandom() : pick_key());
			pause();
		end

		// random mix in bursts
		for (int i = 0; i < 500; i += burst) begin
			burst = $urandom_range(1, 20);
			for (int j = 0; j < burst; j++) begin
				case ($urandom_range(0, 19))
					0: send_req(REQ_RSVD, $urandom());
					1, 2, 3, 4, 5, 6, 7: send_req(REQ_ADD, pick_key());
					8, 9, 10, 11, 12, 13: send_req(REQ_SEARCH, pick_key());
					default: send_req(REQ_ERASE, pick_key());
				endcase
			end
			start <= 1'b0;
			repeat ($urandom_range(0, 30)) @(posedge clk);
		end
		start <= 1'b0;
		@(posedge clk);

		// wait for the last result, then a short tail for stray strobes
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end
endmodule

@@ sim.f @@
rtl/slsm_pkg.sv
rtl/slsm_datapath.sv
rtl/slsm_ctrl.sv
rtl/skip_list_sorted_multiset.sv
tb/slsm_checker.sv
tb/skip_list_sorted_multiset_tb.sv
